FILE: rtl/mofms_pkg.sv
// ----------------------------------------------------------------------------
// Frame mark scheduler package
// Shared types and constants for the frame mark scheduler.
// ----------------------------------------------------------------------------
package mofms_pkg;

  typedef struct packed {
    logic        req_type;
    logic [31:0] frame_id;
    logic        key_req;
    logic [15:0] gap_len;
    logic [2:0]  out_sel;
  } in_item_t;

  typedef struct packed {
    logic        repeat_frame;
    logic [31:0] frame_number;
    logic        keyframe_flag;
    logic        skip_flag;
    logic [15:0] gap_frames;
    logic [2:0]  status;
  } out_item_t;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_KEY_DUP   = 3'd1;
  localparam logic [2:0] ST_KEY_PAST  = 3'd2;
  localparam logic [2:0] ST_MISS_KEY  = 3'd3;
  localparam logic [2:0] ST_MISS_GAP  = 3'd4;
  localparam logic [2:0] ST_MISS_SKIP = 3'd5;
  localparam logic [2:0] ST_FULL      = 3'd6;

  localparam logic CFG_OUTPUT_COUNT = 1'b0;
  localparam logic CFG_HALF_MASK    = 1'b1;

  typedef enum logic [2:0] {
    CMD_IDLE,
    CMD_START,
    CMD_GAP,
    CMD_KEY_RD,
    CMD_KEY,
    CMD_SC_RD,
    CMD_SC
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t    op;
    logic [3:0] outp;
  } cmd_t;

  typedef struct packed {
    logic [3:0] n_used;
    logic       key_stop;
  } stat_t;

endpackage

FILE: rtl/mofms_datapath.sv
// ----------------------------------------------------------------------------
// Frame mark scheduler datapath
// Counters, per-output mark queues and result assembly.
// ----------------------------------------------------------------------------
module mofms_datapath import mofms_pkg::*; #(
  parameter int MAX_OUTPUTS = 8,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cmd_t      cmd,
  output stat_t     stat,
  input  in_item_t  item,
  input  logic      cfg_we,
  input  logic      cfg_idx,
  input  logic [7:0] cfg_val,
  output out_item_t res
);

  localparam int OW = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int MW = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) + QW : QW;

  logic [3:0]  out_cnt_r;
  logic [7:0]  half_r;
  logic [31:0] rep_total_r;
  logic [31:0] sc_cnt_r [MAX_OUTPUTS];
  logic [QW-1:0] kh_r [MAX_OUTPUTS], gh_r [MAX_OUTPUTS], sh_r [MAX_OUTPUTS];
  logic [CW-1:0] kc_r [MAX_OUTPUTS], gc_r [MAX_OUTPUTS], sc_r [MAX_OUTPUTS];
  logic [31:0] key_mem [MAX_OUTPUTS*QUEUE_DEPTH];
  logic [47:0] gap_mem [MAX_OUTPUTS*QUEUE_DEPTH];
  logic [31:0] skip_mem [MAX_OUTPUTS*QUEUE_DEPTH];
  logic [31:0] key_rd_r, skip_rd_r;
  logic [47:0] gap_rd_r;
  logic [31:0] cur_r;
  logic        rep_r, key_stop_r;
  out_item_t   res_r;

  logic [3:0]    n_used;
  logic [7:0]    mask_used;
  logic          any_half;
  logic [OW-1:0] o;
  logic          o_half;

  function automatic logic [MW-1:0] addr(input logic [OW-1:0] ob, input logic [QW-1:0] x);
    logic [MW-1:0] a;
    a = MW'(ob) * MW'(QUEUE_DEPTH) + MW'(x);
    return a;
  endfunction

  // Queue positions wrap at the queue depth, which need not be a power of two.
  function automatic logic [QW-1:0] qwrap(input logic [QW:0] s);
    logic [QW:0] t;
    t = (s >= (QW+1)'(QUEUE_DEPTH)) ? s - (QW+1)'(QUEUE_DEPTH) : s;
    return t[QW-1:0];
  endfunction

  assign n_used = ({1'b0, out_cnt_r} > 5'(MAX_OUTPUTS)) ? 4'(MAX_OUTPUTS) : out_cnt_r;
  assign mask_used = (n_used >= 4'd8) ? 8'hFF : 8'((9'd1 << n_used) - 9'd1);
  assign any_half = (half_r & mask_used) != 8'd0;
  assign o = OW'(cmd.outp);
  assign o_half = (cmd.outp < 4'd8) && half_r[cmd.outp[2:0]];
  assign stat.n_used = n_used;
  assign stat.key_stop = key_stop_r;
  assign res = res_r;

  always_ff @(posedge clk) begin
    logic [2:0]  st;
    logic [31:0] g, k, num, at;
    logic [QW-1:0] slot;
    logic        rep;
    out_item_t   r0;
    st = res_r.status;
    if (!rst_n) begin
      out_cnt_r <= 4'd1;
      half_r <= 8'd0;
      rep_total_r <= 32'd0;
      key_stop_r <= 1'b0;
      for (int i = 0; i < MAX_OUTPUTS; i++) begin
        sc_cnt_r[i] <= 32'd0;
        kh_r[i] <= '0; gh_r[i] <= '0; sh_r[i] <= '0;
        kc_r[i] <= '0; gc_r[i] <= '0; sc_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        if (cfg_idx == CFG_OUTPUT_COUNT) out_cnt_r <= cfg_val[3:0];
        else half_r <= cfg_val;
      end
      case (cmd.op)
        CMD_START: begin
          rep = !item.req_type && item.gap_len != 16'd0 && any_half &&
                (item.frame_id[0] ^ rep_total_r[0]);
          r0 = '0;
          r0.repeat_frame = rep;
          res_r <= r0;
          key_stop_r <= 1'b0;
          rep_r <= rep;
          cur_r <= item.frame_id + rep_total_r + {31'd0, rep};
          if (rep) rep_total_r <= rep_total_r + 32'd1;
        end
        CMD_GAP: begin
          g = {16'd0, item.gap_len} - {31'd0, rep_r};
          at = o_half ? {1'b0, cur_r[31:1]} : cur_r;
          if (g != 32'd0) begin
            if (gc_r[o] >= CW'(QUEUE_DEPTH)) begin
              if (st == ST_OK) st = ST_FULL;
            end else begin
              slot = qwrap({1'b0, gh_r[o]} + (QW+1)'(gc_r[o]));
              gap_mem[addr(o, slot)] <= {g[15:0], at};
              gc_r[o] <= gc_r[o] + CW'(1);
            end
          end
          if (!o_half && rep_r) begin
            if (sc_r[o] >= CW'(QUEUE_DEPTH)) begin
              if (st == ST_OK) st = ST_FULL;
            end else begin
              slot = qwrap({1'b0, sh_r[o]} + (QW+1)'(sc_r[o]));
              skip_mem[addr(o, slot)] <= cur_r - 32'd1;
              sc_r[o] <= sc_r[o] + CW'(1);
            end
          end
          res_r.status <= st;
        end
        CMD_KEY_RD, CMD_SC_RD: begin
          key_rd_r <= key_mem[addr(o, kh_r[o])];
          skip_rd_r <= skip_mem[addr(o, sh_r[o])];
          gap_rd_r <= gap_mem[addr(o, gh_r[o])];
        end
        CMD_KEY: begin
          k = item.frame_id + rep_total_r;
          if (o_half) begin
            k = k + 32'd1;
            k = {1'b0, k[31:1]};
          end
          if (kc_r[o] != CW'(0) && key_rd_r == k && o_half) begin
          end else if (kc_r[o] != CW'(0) && key_rd_r == k) begin
            if (st == ST_OK) st = ST_KEY_DUP;
            key_stop_r <= 1'b1;
          end else if (kc_r[o] != CW'(0) && key_rd_r > k) begin
            if (st == ST_OK) st = ST_KEY_PAST;
            key_stop_r <= 1'b1;
          end else if (kc_r[o] >= CW'(QUEUE_DEPTH)) begin
            if (st == ST_OK) st = ST_FULL;
          end else begin
            slot = qwrap({1'b0, kh_r[o]} + (QW+1)'(kc_r[o]));
            key_mem[addr(o, slot)] <= k;
            kc_r[o] <= kc_r[o] + CW'(1);
          end
          res_r.status <= st;
        end
        CMD_SC: begin
          if (cmd.outp < n_used) begin
            num = sc_cnt_r[o];
            sc_cnt_r[o] <= num + 32'd1;
            res_r.frame_number <= num;
            st = ST_OK;
            if (kc_r[o] != CW'(0)) begin
              if (key_rd_r == num) begin
                kh_r[o] <= qwrap({1'b0, kh_r[o]} + (QW+1)'(1));
                kc_r[o] <= kc_r[o] - CW'(1);
                res_r.keyframe_flag <= 1'b1;
              end else if (key_rd_r < num) st = ST_MISS_KEY;
            end
            if (st == ST_OK && sc_r[o] != CW'(0)) begin
              if (skip_rd_r < num) st = ST_MISS_SKIP;
              else if (skip_rd_r == num) begin
                sh_r[o] <= qwrap({1'b0, sh_r[o]} + (QW+1)'(1));
                sc_r[o] <= sc_r[o] - CW'(1);
                res_r.skip_flag <= 1'b1;
              end
            end
            if (st == ST_OK && gc_r[o] != CW'(0)) begin
              if (gap_rd_r[31:0] < num) st = ST_MISS_GAP;
              else if (gap_rd_r[31:0] == num) begin
                res_r.gap_frames <= gap_rd_r[47:32];
                gh_r[o] <= qwrap({1'b0, gh_r[o]} + (QW+1)'(1));
                gc_r[o] <= gc_r[o] - CW'(1);
              end
            end
            res_r.status <= st;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/mofms_ctrl.sv
// ----------------------------------------------------------------------------
// Frame mark scheduler controller
// Sequences the per-output passes of one transaction.
// ----------------------------------------------------------------------------
module mofms_ctrl import mofms_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_fire,
  input  in_item_t item,
  input  stat_t    stat,
  input  logic     out_fire,
  output logic     busy,
  output logic     out_valid,
  output cmd_t     cmd
);

  localparam logic [2:0] S_IDLE = 3'd0, S_START = 3'd1, S_GAP = 3'd2,
                         S_KRD = 3'd3, S_KEY = 3'd4, S_SRD = 3'd5,
                         S_SC = 3'd6, S_OUT = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic [3:0] o_r, o_nxt;

  assign busy = state_r != S_IDLE;
  assign out_valid = state_r == S_OUT;

  always_comb begin
    state_nxt = state_r;
    o_nxt = o_r;
    cmd.outp = o_r;
    cmd.op = CMD_IDLE;
    unique case (state_r)
      S_IDLE: if (in_fire) state_nxt = S_START;
      S_START: begin
        cmd.op = CMD_START;
        o_nxt = 4'd0;
        if (item.req_type) begin
          o_nxt = {1'b0, item.out_sel};
          state_nxt = S_SRD;
        end else if (item.gap_len != 16'd0 && stat.n_used != 4'd0) state_nxt = S_GAP;
        else if (item.key_req && stat.n_used != 4'd0) state_nxt = S_KRD;
        else state_nxt = S_OUT;
      end
      S_GAP: begin
        cmd.op = CMD_GAP;
        o_nxt = o_r + 4'd1;
        if (o_r + 4'd1 >= stat.n_used) begin
          o_nxt = 4'd0;
          state_nxt = item.key_req ? S_KRD : S_OUT;
        end
      end
      S_KRD: begin
        cmd.op = CMD_KEY_RD;
        state_nxt = S_KEY;
      end
      S_KEY: begin
        cmd.op = CMD_KEY;
        o_nxt = o_r + 4'd1;
        state_nxt = (o_r + 4'd1 >= stat.n_used) ? S_OUT : S_KRD;
      end
      S_SRD: begin
        cmd.op = CMD_SC_RD;
        state_nxt = S_SC;
      end
      S_SC: begin
        cmd.op = CMD_SC;
        state_nxt = S_OUT;
      end
      S_OUT: if (out_fire) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
    if (state_r == S_KRD && stat.key_stop) state_nxt = S_OUT;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      o_r <= 4'd0;
    end else begin
      state_r <= state_nxt;
      o_r <= o_nxt;
    end
  end

endmodule

FILE: rtl/multi_output_frame_mark_scheduler.sv
// ----------------------------------------------------------------------------
// Multi-output frame mark scheduler
// Channel | Direction | Handshake
// in_     | input     | in_valid / in_stall
// out_    | output    | out_valid / out_stall
// cfg_    | input     | cfg_valid / cfg_ready
// A source transaction holds the controller through start, a gap pass per output
// in use, a keyframe read and check per output, result hand-off and idle; skipped
// passes drop out. A scaled transaction runs start, a queue read, the scaled pass, result hand-off and idle.
// The result sits in an output register, so a stalled result holds the input
// only once the next result is ready behind it. Reset is synchronous and
// clears counters, queue pointers and the output valid flag.
// ----------------------------------------------------------------------------
module multi_output_frame_mark_scheduler import mofms_pkg::*; #(
  parameter int MAX_OUTPUTS = 8,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_index,
  input  logic [7:0] cfg_data
);

  in_item_t  item_r;
  cmd_t      cmd;
  stat_t     stat;
  logic      busy, in_fire;
  logic      dp_valid, out_load;
  out_item_t dp_res;
  logic      out_valid_r;
  out_item_t out_data_r;

  assign in_stall = busy;
  assign in_fire = in_valid && !busy;
  assign cfg_ready = 1'b1;
  assign out_load = dp_valid && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

  always_ff @(posedge clk) begin
    if (in_fire) item_r <= in_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_data_r <= dp_res;
  end

  mofms_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .item(item_r), .stat,
    .out_fire(out_load), .busy, .out_valid(dp_valid), .cmd
  );

  mofms_datapath #(.MAX_OUTPUTS(MAX_OUTPUTS), .QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
    .clk, .rst_n, .cmd, .stat, .item(item_r),
    .cfg_we(cfg_valid), .cfg_idx(cfg_index), .cfg_val(cfg_data), .res(dp_res)
  );

endmodule

FILE: tb/multi_output_frame_mark_scheduler_tb.sv
// ----------------------------------------------------------------------------
// Multi-output frame mark scheduler testbench
// Drives source and scaled frame transactions under random bursts and output
// stalls across several output settings. Each result is checked field by
// field against a behavioral model of the keyframe, gap and skip mark queues.
// ----------------------------------------------------------------------------
module multi_output_frame_mark_scheduler_tb;
  import mofms_pkg::*;

  localparam int NOUT = 8;
  localparam int QD = 16;
  localparam int QK = 0;
  localparam int QG = 1;
  localparam int QS = 2;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_index = CFG_OUTPUT_COUNT;
  logic [7:0] cfg_data = '0;

  multi_output_frame_mark_scheduler DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  logic [3:0]  m_outputs = 4'd1;
  logic [7:0]  m_half = 8'd0;
  logic [31:0] m_repeats = '0;
  logic [31:0] m_counts [NOUT];
  logic [31:0] m_key [NOUT][QD];
  logic [31:0] m_skip [NOUT][QD];
  logic [31:0] m_gap_pos [NOUT][QD];
  logic [15:0] m_gap_len [NOUT][QD];
  int          m_head [3][NOUT];
  int          m_cnt [3][NOUT];

  in_item_t  pending_items [$];
  out_item_t expected_marks [$];
  bit        failed = 1'b0;
  bit        in_taken = 1'b0;
  int        burst_left = 0;
  int        gap_left = 0;
  int        stall_mode = 0;
  int        stall_timer = 0;

  initial begin
    for (int o = 0; o < NOUT; o++) begin
      m_counts[o] = '0;
      for (int q = 0; q < 3; q++) begin
        m_head[q][o] = 0;
        m_cnt[q][o] = 0;
      end
    end
  end

  function automatic void note_status(inout logic [2:0] st, input logic [2:0] code);
    if (st == ST_OK) st = code;
  endfunction

  function automatic int claim_slot(int q, int o, inout logic [2:0] st);
    int slot;
    if (m_cnt[q][o] >= QD) begin
      note_status(st, ST_FULL);
      return -1;
    end
    slot = (m_head[q][o] + m_cnt[q][o]) % QD;
    m_cnt[q][o]++;
    return slot;
  endfunction

  function automatic void drop_front(int q, int o);
    m_head[q][o] = (m_head[q][o] + 1) % QD;
    m_cnt[q][o]--;
  endfunction

  function automatic out_item_t schedule_marks(in_item_t it);
    out_item_t r;
    int n;
    int s;
    logic [7:0] used;
    logic rep;
    logic half;
    logic [31:0] cur;
    logic [31:0] k;
    logic [31:0] num;
    logic [31:0] front;
    logic [15:0] g;
    r = '0;
    rep = 1'b0;
    n = (m_outputs > NOUT) ? NOUT : int'(m_outputs);
    used = (n >= 8) ? 8'hFF : 8'((1 << n) - 1);
    if (it.req_type == 1'b0) begin
      if (it.gap_len != 0) begin
        cur = it.frame_id + m_repeats;
        if ((m_half & used) != 0 && cur[0]) begin
          rep = 1'b1;
          m_repeats++;
          cur++;
        end
        for (int o = 0; o < n; o++) begin
          half = m_half[o];
          g = rep ? it.gap_len - 16'd1 : it.gap_len;
          if (g != 0) begin
            s = claim_slot(QG, o, r.status);
            if (s >= 0) begin
              m_gap_pos[o][s] = half ? cur / 2 : cur;
              m_gap_len[o][s] = g;
            end
          end
          if (!half && rep) begin
            s = claim_slot(QS, o, r.status);
            if (s >= 0) m_skip[o][s] = cur - 32'd1;
          end
        end
      end
      if (it.key_req) begin
        for (int o = 0; o < n; o++) begin
          half = m_half[o];
          k = it.frame_id + m_repeats;
          if (half) k = (k + 32'd1) / 2;
          if (m_cnt[QK][o] != 0) begin
            front = m_key[o][m_head[QK][o]];
            if (front == k && half) continue;
            if (front == k) begin
              note_status(r.status, ST_KEY_DUP);
              break;
            end
            if (front > k) begin
              note_status(r.status, ST_KEY_PAST);
              break;
            end
          end
          s = claim_slot(QK, o, r.status);
          if (s >= 0) m_key[o][s] = k;
        end
      end
      r.repeat_frame = rep;
      return r;
    end
    if (int'(it.out_sel) >= n) return r;
    num = m_counts[it.out_sel];
    m_counts[it.out_sel] = num + 32'd1;
    r.frame_number = num;
    if (m_cnt[QK][it.out_sel] != 0) begin
      front = m_key[it.out_sel][m_head[QK][it.out_sel]];
      if (front == num) begin
        drop_front(QK, it.out_sel);
        r.keyframe_flag = 1'b1;
      end else if (front < num) begin
        note_status(r.status, ST_MISS_KEY);
        return r;
      end
    end
    if (m_cnt[QS][it.out_sel] != 0) begin
      front = m_skip[it.out_sel][m_head[QS][it.out_sel]];
      if (front < num) begin
        note_status(r.status, ST_MISS_SKIP);
        return r;
      end
      if (front == num) begin
        drop_front(QS, it.out_sel);
        r.skip_flag = 1'b1;
      end
    end
    if (m_cnt[QG][it.out_sel] != 0) begin
      front = m_gap_pos[it.out_sel][m_head[QG][it.out_sel]];
      if (front < num) begin
        note_status(r.status, ST_MISS_GAP);
        return r;
      end
      if (front == num) begin
        r.gap_frames = m_gap_len[it.out_sel][m_head[QG][it.out_sel]];
        drop_front(QG, it.out_sel);
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    in_taken <= in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) expected_marks.push_back(schedule_marks(in_data));
    if (rst_n && out_valid && !out_stall) begin
      if (expected_marks.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, actual %h", $time, out_data);
        failed = 1'b1;
      end else begin
        out_item_t e;
        e = expected_marks.pop_front();
        if (out_data.repeat_frame !== e.repeat_frame) begin
          $display("%0t: repeat_frame expected %0d actual %0d", $time, e.repeat_frame,
                   out_data.repeat_frame);
          failed = 1'b1;
        end
        if (out_data.frame_number !== e.frame_number) begin
          $display("%0t: frame_number expected %0d actual %0d", $time, e.frame_number,
                   out_data.frame_number);
          failed = 1'b1;
        end
        if (out_data.keyframe_flag !== e.keyframe_flag) begin
          $display("%0t: keyframe_flag expected %0d actual %0d", $time, e.keyframe_flag,
                   out_data.keyframe_flag);
          failed = 1'b1;
        end
        if (out_data.skip_flag !== e.skip_flag) begin
          $display("%0t: skip_flag expected %0d actual %0d", $time, e.skip_flag,
                   out_data.skip_flag);
          failed = 1'b1;
        end
        if (out_data.gap_frames !== e.gap_frames) begin
          $display("%0t: gap_frames expected %0d actual %0d", $time, e.gap_frames,
                   out_data.gap_frames);
          failed = 1'b1;
        end
        if (out_data.status !== e.status) begin
          $display("%0t: status expected %0d actual %0d", $time, e.status, out_data.status);
          failed = 1'b1;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (burst_left == 0 && gap_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      end
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        in_data <= pending_items.pop_front();
        in_valid <= 1'b1;
        burst_left--;
      end else begin
        in_valid <= 1'b0;
      end
    end
    if (stall_timer == 0) begin
      stall_timer = $urandom_range(16, 96);
      stall_mode = $urandom_range(0, 2);
    end
    stall_timer--;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  task automatic write_reg(logic idx, logic [7:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_OUTPUT_COUNT) m_outputs = value[3:0];
    else m_half = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic add_item(logic rt, logic [31:0] fid, logic key, logic [15:0] gap,
                          logic [2:0] oid);
    in_item_t it;
    it.req_type = rt;
    it.frame_id = fid;
    it.key_req = key;
    it.gap_len = gap;
    it.out_sel = oid;
    pending_items.push_back(it);
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || in_valid || expected_marks.size() != 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  logic [31:0] next_fid = '0;

  task automatic random_phase(int count);
    in_item_t it;
    for (int i = 0; i < count; i++) begin
      it = in_item_t'({$urandom, $urandom});
      if ($urandom_range(0, 9) == 0) begin
        pending_items.push_back(it);
      end else if ($urandom_range(0, 9) < 4) begin
        next_fid += $urandom_range(0, 3) == 0 ? $urandom_range(2, 4) : 1;
        add_item(1'b0, next_fid, $urandom_range(0, 3) == 0,
                 $urandom_range(0, 7) == 0 ? 16'($urandom) : 16'($urandom_range(0, 3)),
                 it.out_sel);
      end else begin
        add_item(1'b1, it.frame_id, it.key_req, it.gap_len,
                 m_outputs == 0 ? it.out_sel : 3'($urandom_range(0, m_outputs - 1) % 8));
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    write_reg(CFG_OUTPUT_COUNT, 8'd3);
    write_reg(CFG_HALF_MASK, 8'h02);
    add_item(1'b0, 32'd0, 1'b1, 16'd0, 3'd0);
    add_item(1'b0, 32'd1, 1'b1, 16'd2, 3'd7);
    add_item(1'b0, 32'd1, 1'b1, 16'd0, 3'd0);
    add_item(1'b0, 32'd0, 1'b1, 16'd0, 3'd0);
    add_item(1'b0, 32'd3, 1'b0, 16'd1, 3'd0);
    for (int i = 0; i < 4; i++) begin
      add_item(1'b1, '1, 1'b1, '1, 3'd0);
      add_item(1'b1, '0, 1'b0, '0, 3'd1);
      add_item(1'b1, '0, 1'b0, '0, 3'd2);
    end
    add_item(1'b1, '0, 1'b0, '0, 3'd7);
    add_item(1'b0, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 3'd7);
    add_item(1'b0, 32'hFFFF_FFFE, 1'b1, 16'hFFFF, 3'd0);
    add_item(1'b1, '0, 1'b0, '0, 3'd1);
    add_item(1'b1, '0, 1'b0, '0, 3'd0);
    drain();
    for (int i = 0; i < 20; i++) add_item(1'b0, 32'd100 + i, 1'b1, 16'd3, 3'd0);
    drain();
    write_reg(CFG_OUTPUT_COUNT, 8'd1);
    write_reg(CFG_HALF_MASK, 8'h00);
    random_phase(100);
    drain();
    write_reg(CFG_OUTPUT_COUNT, 8'd8);
    write_reg(CFG_HALF_MASK, 8'hFF);
    random_phase(100);
    drain();
    write_reg(CFG_OUTPUT_COUNT, 8'd0);
    random_phase(60);
    drain();
    write_reg(CFG_OUTPUT_COUNT, 8'd15);
    write_reg(CFG_HALF_MASK, 8'h55);
    random_phase(120);
    drain();
    write_reg(CFG_OUTPUT_COUNT, 8'd8);
    write_reg(CFG_HALF_MASK, 8'hAA);
    random_phase(120);
    drain();
    write_reg(CFG_OUTPUT_COUNT, 8'd5);
    write_reg(CFG_HALF_MASK, 8'h10);
    random_phase(120);
    drain();
    write_reg(CFG_OUTPUT_COUNT, 8'd2);
    write_reg(CFG_HALF_MASK, 8'h00);
    random_phase(120);
    drain();
    write_reg(CFG_OUTPUT_COUNT, 8'd4);
    write_reg(CFG_HALF_MASK, 8'hF3);
    random_phase(120);
    drain();
    if (!failed) begin
      $display("PASS multi_output_frame_mark_scheduler");
    end else begin
      $display("FAIL multi_output_frame_mark_scheduler");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL multi_output_frame_mark_scheduler");
    $finish;
  end

endmodule
